// ===== rtl/mstk_pkg.sv =====
// package for the kruskal spanning tree unit: payload types and sizes
// no dependencies
package mstk_pkg;

   localparam int MaxVertices = 16;
   localparam int MaxEdges    = 64;
   localparam int VtxW        = $clog2(MaxVertices);
   localparam int EdgeIdxW    = $clog2(MaxEdges);
   localparam int EdgeCntW    = EdgeIdxW + 1;

   typedef struct packed {
      logic [3:0]         in_source;
      logic [3:0]         in_dest;
      logic signed [15:0] in_weight;
      logic               last_edge;
   } req_type;

   typedef struct packed {
      logic               edge_valid;
      logic [3:0]         edge_source;
      logic [3:0]         edge_dest;
      logic signed [15:0] edge_weight;
      logic signed [19:0] total_weight;
      logic               load_error;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [VtxW-1:0]    src;
      logic [VtxW-1:0]    dst;
      logic signed [15:0] wt;
   } edge_type;

endpackage

// ===== rtl/mstk_sort.sv =====
// stable insertion sort of the edge store, one compare at a time
// depends on mstk_pkg
module mstk_sort
   import mstk_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load_we,
   input  logic [EdgeIdxW-1:0] load_addr,
   input  edge_type            load_data,
   input  logic                start,
   input  logic [EdgeCntW-1:0] count,
   output logic                done,
   input  logic [EdgeIdxW-1:0] rd_addr,
   output edge_type            rd_data
);

   typedef enum logic [2:0] {S_IDLE, S_RDI, S_KEY, S_RDJ, S_CMP, S_DONE} state_type;

   edge_type store_mem [MaxEdges];
   edge_type sort_mem  [MaxEdges];
   edge_type key_ff, srd_ff, st_rd_ff;
   state_type state_ff;
   logic [EdgeCntW-1:0] i_ff, j_ff;
   logic [EdgeIdxW-1:0] sort_raddr;
   logic sort_we;
   logic [EdgeIdxW-1:0] sort_waddr;
   edge_type sort_wdata;

   always_ff @(posedge clock) begin
      if (load_we) store_mem[load_addr] <= load_data;
      st_rd_ff <= store_mem[i_ff[EdgeIdxW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (sort_we) sort_mem[sort_waddr] <= sort_wdata;
      srd_ff <= sort_mem[sort_raddr];
   end

   // the scan reads sorted data while idle
   always_comb begin
      sort_raddr = rd_addr;
      if (state_ff != S_IDLE && state_ff != S_DONE)
         sort_raddr = EdgeIdxW'(j_ff - 1'b1);
   end
   assign rd_data = srd_ff;

   always_comb begin
      sort_we    = 1'b0;
      sort_waddr = j_ff[EdgeIdxW-1:0];
      sort_wdata = key_ff;
      if (state_ff == S_CMP) begin
         sort_we = 1'b1;
         if (j_ff != '0 && srd_ff.wt > key_ff.wt) sort_wdata = srd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (start) begin
               i_ff     <= '0;
               state_ff <= (count == '0) ? S_DONE : S_RDI;
            end
            S_RDI: state_ff <= S_KEY;
            S_KEY: begin
               key_ff   <= st_rd_ff;
               j_ff     <= i_ff;
               state_ff <= S_RDJ;
            end
            // read of entry j-1 in flight
            S_RDJ: state_ff <= S_CMP;
            S_CMP: begin
               if (j_ff != '0 && srd_ff.wt > key_ff.wt) begin
                  // shifted one up, step down and keep the key
                  j_ff     <= j_ff - 1'b1;
                  state_ff <= S_RDJ;
               end else if (i_ff + 1'b1 == count) begin
                  state_ff <= S_DONE;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_RDI;
               end
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done = (state_ff == S_DONE);

endmodule

// ===== rtl/minimum_spanning_tree_kruskal_unit.sv =====
// top level of the kruskal spanning tree unit
// depends on mstk_pkg and mstk_sort
//
// usage: edges enter one per request on req_ (valid/ready); each is checked
// against the vertex count and the store size and, if it passes, written to
// the edge store (else dropped and the drop flag set), so loads run at one
// request per cycle. the request with last_edge set starts the run: an
// insertion sort over the store, then a scan that runs union-find
// with path compression over a flip-flop parent table, one parent hop per
// cycle. tree edges leave on rsp_ in acceptance order with the running
// total; each one waits in a holding register until the next tree edge or
// the end of the scan is found, so the final one can carry last. an empty
// tree gives a single response with edge_valid low. a stalled receiver
// simply holds the scan, the response register keeps its value. req_ready
// is low from the last edge until the final response is loaded into the
// response register. reset (synchronous) empties the store, clears the drop
// flag and sets vertex_count to 16. csr_ writes land at once.
module minimum_spanning_tree_kruskal_unit
   import mstk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [4:0] csr_wdata
);

   typedef enum logic [3:0] {
      T_LOAD, T_SORT, T_RD, T_WAIT, T_FX, T_FY, T_JOIN, T_CX, T_CY, T_OUT, T_END
   } state_type;

   state_type state_ff;
   logic [4:0] vcnt_ff;
   logic [EdgeCntW-1:0] ecnt_ff, idx_ff;
   logic drop_ff;
   logic [VtxW-1:0] parent_ff [MaxVertices];
   logic [VtxW-1:0] rx_ff, ry_ff, walk_ff, taken_ff;
   edge_type cur_ff;
   logic signed [19:0] total_ff;
   logic any_ff;
   rsp_type rsp_ff;
   rsp_type pend_ff;
   rsp_type pend_last;
   logic rsp_valid_ff;
   logic out_free, rsp_push;
   logic sort_done;
   edge_type sort_rd;
   logic [VtxW:0] nv;
   logic req_fire, bad;

   always_comb begin
      nv = vcnt_ff < 5'd2 ? (VtxW+1)'(2) :
           (vcnt_ff > 5'(MaxVertices) ? (VtxW+1)'(MaxVertices) : vcnt_ff[VtxW:0]);
   end

   assign req_ready = (state_ff == T_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign bad = (ecnt_ff == EdgeCntW'(MaxEdges)) || ({1'b0, req_data.in_source} >= nv)
                || ({1'b0, req_data.in_dest} >= nv);

   mstk_sort u_sort (
      .clock     (clock),
      .reset     (reset),
      .load_we   (req_fire && !bad),
      .load_addr (ecnt_ff[EdgeIdxW-1:0]),
      .load_data (edge_type'{src: req_data.in_source, dst: req_data.in_dest,
                             wt: req_data.in_weight}),
      .start     (state_ff == T_SORT),
      .count     (ecnt_ff),
      .done      (sort_done),
      .rd_addr   (idx_ff[EdgeIdxW-1:0]),
      .rd_data   (sort_rd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // held tree edge marked as the final one
   always_comb begin
      pend_last      = pend_ff;
      pend_last.last = 1'b1;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_push = out_free && ((state_ff == T_OUT && any_ff) || state_ff == T_END);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_LOAD;
         vcnt_ff      <= 5'd16;
         ecnt_ff      <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int v = 0; v < MaxVertices; v++) parent_ff[v] <= VtxW'(v);
      end else begin
         if (csr_we) vcnt_ff <= csr_wdata;
         if (rsp_push) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            T_LOAD: if (req_fire) begin
               if (bad) drop_ff <= 1'b1;
               else ecnt_ff <= ecnt_ff + 1'b1;
               if (req_data.last_edge) state_ff <= T_SORT;
            end
            T_SORT: begin
               idx_ff   <= '0;
               taken_ff <= '0;
               total_ff <= '0;
               any_ff   <= 1'b0;
               for (int v = 0; v < MaxVertices; v++) parent_ff[v] <= VtxW'(v);
               state_ff <= T_WAIT;
            end
            T_WAIT: if (sort_done) state_ff <= T_RD;
            T_RD: begin
               if (idx_ff == ecnt_ff || {1'b0, taken_ff} == nv - 1'b1) state_ff <= T_END;
               else state_ff <= T_FX; // rd_data valid next cycle
            end
            T_FX: begin
               cur_ff <= sort_rd;
               if ({1'b0, sort_rd.src} >= nv || {1'b0, sort_rd.dst} >= nv) begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= T_RD;
               end else begin
                  rx_ff <= sort_rd.src; state_ff <= T_FY;
               end
            end
            T_FY: begin // find root of src
               if (parent_ff[rx_ff] != rx_ff) rx_ff <= parent_ff[rx_ff];
               else begin walk_ff <= cur_ff.src; state_ff <= T_CX; end
            end
            T_CX: begin // compress src path
               if (walk_ff != rx_ff) begin
                  parent_ff[walk_ff] <= rx_ff; walk_ff <= parent_ff[walk_ff];
               end else begin ry_ff <= cur_ff.dst; state_ff <= T_JOIN; end
            end
            T_JOIN: begin // find root of dst
               if (parent_ff[ry_ff] != ry_ff) ry_ff <= parent_ff[ry_ff];
               else begin walk_ff <= cur_ff.dst; state_ff <= T_CY; end
            end
            T_CY: begin
               if (walk_ff != ry_ff) begin
                  parent_ff[walk_ff] <= ry_ff; walk_ff <= parent_ff[walk_ff];
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  if (rx_ff != ry_ff) begin
                     parent_ff[rx_ff] <= ry_ff;
                     state_ff <= T_OUT;
                  end else state_ff <= T_RD;
               end
            end
            T_OUT: if (!any_ff || out_free) begin
               // the held edge is not the final one, send it and hold the new one
               if (any_ff) rsp_ff <= pend_ff;
               pend_ff <= '{edge_valid: 1'b1, edge_source: cur_ff.src,
                            edge_dest: cur_ff.dst, edge_weight: cur_ff.wt,
                            total_weight: total_ff + 20'(cur_ff.wt),
                            load_error: drop_ff, last: 1'b0};
               total_ff <= total_ff + 20'(cur_ff.wt);
               taken_ff <= taken_ff + 1'b1;
               any_ff   <= 1'b1;
               state_ff <= T_RD;
            end
            T_END: if (out_free) begin
               if (any_ff) rsp_ff <= pend_last;
               else rsp_ff <= '{edge_valid: 1'b0, edge_source: '0, edge_dest: '0,
                                edge_weight: '0, total_weight: '0,
                                load_error: drop_ff, last: 1'b1};
               ecnt_ff  <= '0;
               drop_ff  <= 1'b0;
               state_ff <= T_LOAD;
            end
            default: state_ff <= T_LOAD;
         endcase
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   a_no_req: assert property (@(posedge clock) disable iff (reset)
      state_ff != T_LOAD |-> !req_ready)
      else $error("request taken during run");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      ecnt_ff <= EdgeCntW'(MaxEdges))
      else $error("edge count overflow");

endmodule
